### sv/trd_pkg.sv
// ============================================================================
// Triangle raster depth test: shared package
// Types, codes and fixed widths used by the rasteriser and its datapath units.
// ============================================================================
package trd_pkg;

    // Frame and store geometry
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int SUBPIXEL_BITS = 4;
    localparam int DEPTH_BITS    = 24;
    localparam int STORE_SIZE    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W        = 16;
    localparam int DIM_W         = 9;
    localparam int PIX_W         = 8;
    localparam int COLOR_W       = 32;
    localparam int COUNT_W       = 17;

    // Arithmetic widths
    localparam int COORD_W = 16;   // raw 12.4 coordinate
    localparam int DBL_W   = 17;   // doubled coordinate
    localparam int DIFF_W  = 19;   // coordinate difference
    localparam int MUL_W   = 25;   // shared multiplier operand
    localparam int PROD_W  = 50;   // shared multiplier product
    localparam int ACC_W   = 61;   // accumulator
    localparam int EDGE_W  = 37;   // signed edge value
    localparam int AREA_W  = 36;   // positive area and weights
    localparam int CHUNK_W = 18;   // half of a weight
    localparam int NUM_W   = 60;   // depth numerator

    // Item kinds
    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        kind_t                      kind;
        logic signed [COORD_W-1:0]  x0;
        logic signed [COORD_W-1:0]  y0;
        logic [DEPTH_BITS-1:0]      z0;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y1;
        logic [DEPTH_BITS-1:0]      z1;
        logic signed [COORD_W-1:0]  x2;
        logic signed [COORD_W-1:0]  y2;
        logic [DEPTH_BITS-1:0]      z2;
        logic [COLOR_W-1:0]         fill_color;
        logic [ADDR_W-1:0]          pixel_index;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0]     read_color;
        logic [DEPTH_BITS-1:0]  read_depth;
        logic [COUNT_W-1:0]     pixels_written;
        logic                   culled;
    } result_t;

    // Shared multiply-accumulate unit control
    typedef enum logic [1:0] {
        MAC_NOP  = 2'd0,
        MAC_LOAD = 2'd1,
        MAC_ADD  = 2'd2,
        MAC_SUB  = 2'd3
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
        logic    shift_hi;
    } mac_ctrl_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_AREA,
        ST_AREA_CHK,
        ST_EDGE,
        ST_COVER,
        ST_WSUM,
        ST_DIV,
        ST_MEM_RD,
        ST_MEM_CMP
    } state_t;

endpackage

### sv/trd_ram.sv
// ============================================================================
// Generic single-port RAM
// One address per cycle, with an optional write and a registered read.
// ============================================================================
module trd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/trd_mac.sv
// ============================================================================
// Shared multiply-accumulate unit
// Registered signed product followed by an accumulator with optional shift.
// ============================================================================
module trd_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  trd_pkg::mac_ctrl_t                ctrl,
    input  logic signed [trd_pkg::MUL_W-1:0]  a,
    input  logic signed [trd_pkg::MUL_W-1:0]  b,
    output logic signed [trd_pkg::ACC_W-1:0]  acc
);
    import trd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    mac_ctrl_t                ctrl_reg, ctrl_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  term;

    // Product stage
    always_comb
    begin
        prod_next = a * b;
        ctrl_next = ctrl;
    end

    // Accumulate stage; the upper half of a weight lands one chunk higher
    always_comb
    begin
        term = ctrl_reg.shift_hi ? (ACC_W'(prod_reg) <<< CHUNK_W) : ACC_W'(prod_reg);
        case (ctrl_reg.op)
            MAC_LOAD: acc_next = term;
            MAC_ADD:  acc_next = acc_reg + term;
            MAC_SUB:  acc_next = acc_reg - term;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '{op: MAC_NOP, shift_hi: 1'b0};
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

### sv/trd_div.sv
// ============================================================================
// Depth divider
// Restoring divider, one quotient bit per cycle, for a quotient of depth width.
// ============================================================================
module trd_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [trd_pkg::NUM_W-1:0]         num,
    input  logic [trd_pkg::AREA_W-1:0]        den,
    output logic                              done,
    output logic [trd_pkg::DEPTH_BITS-1:0]    quo
);
    import trd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH_BITS);

    logic [AREA_W-1:0]     rem_reg, rem_next;
    logic [DEPTH_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [AREA_W:0]       trial;
    logic [AREA_W:0]       diff;

    // One shift-compare-subtract step per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DEPTH_BITS-1]};
        diff      = trial - {1'b0, den};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num[NUM_W-1:DEPTH_BITS];
            quo_next = num[DEPTH_BITS-1:0];
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[AREA_W])
            begin
                rem_next = diff[AREA_W-1:0];
                quo_next = {quo_reg[DEPTH_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[AREA_W-1:0];
                quo_next = {quo_reg[DEPTH_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DEPTH_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### sv/triangle_raster_depth_test.sv
// ============================================================================
// Triangle raster depth test
// Edge-function rasteriser with a depth store and a colour store of 64K words.
// ============================================================================
// Read word: both stores are read at the item's pixel index while idle and the
// result is registered in the read state. Kind 3: a zero result is registered
// on acceptance. Clear word: one depth entry written per cycle, whole store.
// Draw word: area setup, then for each box pixel the edge values on one shared MAC;
// a covered pixel adds the weight products on it, the bit-serial divider and a
// read-modify-write of the stores. After reset both stores are swept, busy high.
// ============================================================================
module triangle_raster_depth_test (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  trd_pkg::item_t                 item,
    output logic                           result_valid,
    output trd_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [trd_pkg::DIM_W-1:0]      cfg_data
);
    import trd_pkg::*;

    state_t                   state_reg, state_next;
    item_t                    item_reg, item_next;
    logic [DIM_W-1:0]         frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]         frame_height_reg, frame_height_next;
    logic [ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [2:0]               step_reg, step_next;
    logic [1:0]               k_reg, k_next;
    logic signed [EDGE_W-1:0] e_reg [3];
    logic signed [EDGE_W-1:0] e_next [3];
    logic [AREA_W-1:0]        area_reg, area_next;
    logic [PIX_W-1:0]         x_cnt_reg, x_cnt_next;
    logic [PIX_W-1:0]         y_cnt_reg, y_cnt_next;
    logic [PIX_W-1:0]         lx_reg, lx_next;
    logic [PIX_W-1:0]         hx_reg, hx_next;
    logic [PIX_W-1:0]         hy_reg, hy_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    result_t                  result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    logic                     accept;
    logic                     clr_last;
    logic [DIM_W-1:0]         w_sat, h_sat;
    logic signed [DBL_W-1:0]  vx [3];
    logic signed [DBL_W-1:0]  vy [3];
    logic [DEPTH_BITS-1:0]    zv [3];
    logic [1:0]               eidx, ai, bi;
    logic signed [DIFF_W-1:0] p_x, p_y, d_px, d_py, d_bx, d_by;
    logic [AREA_W-1:0]        wk;
    logic [CHUNK_W-1:0]       chunk;
    mac_ctrl_t                mac_ctrl;
    logic signed [MUL_W-1:0]  mac_a, mac_b;
    logic signed [ACC_W-1:0]  acc;
    logic                     div_start, div_done;
    logic [DEPTH_BITS-1:0]    quo;
    logic                     area_pos, covered, nearer, last_pix;
    logic signed [12:0]       lx_s, ly_s, hx_s, hy_s, wm1, hm1;
    logic signed [COORD_W-1:0] minx, miny, maxx, maxy;
    logic                     box_empty;
    logic [COUNT_W-1:0]       row_base;
    logic [ADDR_W-1:0]        pix_addr;
    logic [ADDR_W-1:0]        ram_addr;
    logic                     depth_we, color_we;
    logic [DEPTH_BITS-1:0]    depth_wdata, depth_rdata;
    logic [COLOR_W-1:0]       color_rdata;

    function automatic logic signed [COORD_W-1:0] min3(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c);
        logic signed [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [COORD_W-1:0] max3(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c);
        logic signed [COORD_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Floor and ceiling of a 12.4 coordinate in whole pixels
    function automatic logic signed [12:0] floor_px(input logic signed [COORD_W-1:0] v);
        logic signed [DBL_W-1:0] t;
        t = DBL_W'(v) >>> SUBPIXEL_BITS;
        return t[12:0];
    endfunction

    function automatic logic signed [12:0] ceil_px(input logic signed [COORD_W-1:0] v);
        logic signed [DBL_W-1:0] t;
        t = (DBL_W'(v) + DBL_W'((1 << SUBPIXEL_BITS) - 1)) >>> SUBPIXEL_BITS;
        return t[12:0];
    endfunction

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign clr_last = &clr_cnt_reg;

    // Frame size saturated to the store geometry
    assign w_sat = (frame_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_reg;
    assign h_sat = (frame_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : frame_height_reg;

    // Configuration writes
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we && (cfg_index == REG_FRAME_WIDTH))
        begin
            frame_width_next = cfg_data;
        end
        if (cfg_we && (cfg_index == REG_FRAME_HEIGHT))
        begin
            frame_height_next = cfg_data;
        end
    end

    // Doubled vertex coordinates so that pixel centres are whole numbers
    always_comb
    begin
        vx[0] = {item_reg.x0, 1'b0};
        vy[0] = {item_reg.y0, 1'b0};
        vx[1] = {item_reg.x1, 1'b0};
        vy[1] = {item_reg.y1, 1'b0};
        vx[2] = {item_reg.x2, 1'b0};
        vy[2] = {item_reg.y2, 1'b0};
        zv[0] = item_reg.z0;
        zv[1] = item_reg.z1;
        zv[2] = item_reg.z2;
    end

    // Edge operand selection; the area is the last edge, taken at the last vertex
    always_comb
    begin
        eidx = (state_reg == ST_AREA) ? 2'd2 : k_reg;
        case (eidx)
            2'd0:
            begin
                ai = 2'd1;
                bi = 2'd2;
            end
            2'd1:
            begin
                ai = 2'd2;
                bi = 2'd0;
            end
            default:
            begin
                ai = 2'd0;
                bi = 2'd1;
            end
        endcase
        if (state_reg == ST_AREA)
        begin
            p_x = DIFF_W'(vx[2]);
            p_y = DIFF_W'(vy[2]);
        end
        else
        begin
            p_x = $signed(DIFF_W'({x_cnt_reg, 1'b1}) << SUBPIXEL_BITS);
            p_y = $signed(DIFF_W'({y_cnt_reg, 1'b1}) << SUBPIXEL_BITS);
        end
        d_px = p_x - DIFF_W'(vx[ai]);
        d_py = p_y - DIFF_W'(vy[ai]);
        d_bx = DIFF_W'(vx[bi]) - DIFF_W'(vx[ai]);
        d_by = DIFF_W'(vy[bi]) - DIFF_W'(vy[ai]);
        wk    = e_reg[step_reg[2:1]][AREA_W-1:0];
        chunk = step_reg[0] ? wk[AREA_W-1:CHUNK_W] : wk[CHUNK_W-1:0];
    end

    // Shared MAC control and operands
    always_comb
    begin
        mac_ctrl = '{op: MAC_NOP, shift_hi: 1'b0};
        mac_a    = MUL_W'(d_px);
        mac_b    = MUL_W'(d_by);
        case (state_reg)
            ST_AREA, ST_EDGE:
            begin
                if (step_reg == 3'd0)
                begin
                    mac_ctrl.op = MAC_LOAD;
                end
                else if (step_reg == 3'd1)
                begin
                    mac_ctrl.op = MAC_SUB;
                    mac_a       = MUL_W'(d_py);
                    mac_b       = MUL_W'(d_bx);
                end
            end
            ST_WSUM:
            begin
                mac_a = $signed(MUL_W'(chunk));
                mac_b = $signed(MUL_W'(zv[step_reg[2:1]]));
                mac_ctrl.shift_hi = step_reg[0];
                if (step_reg == 3'd0)
                begin
                    mac_ctrl.op = MAC_LOAD;
                end
                else if (step_reg < 3'd6)
                begin
                    mac_ctrl.op = MAC_ADD;
                end
            end
            default:
            begin
                mac_ctrl.op = MAC_NOP;
            end
        endcase
    end

    trd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    assign div_start = (state_reg == ST_WSUM) && (step_reg == 3'd7);

    trd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc[NUM_W-1:0]),
        .den   (area_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // Bounding box clamped to the frame
    always_comb
    begin
        minx = min3(item_reg.x0, item_reg.x1, item_reg.x2);
        miny = min3(item_reg.y0, item_reg.y1, item_reg.y2);
        maxx = max3(item_reg.x0, item_reg.x1, item_reg.x2);
        maxy = max3(item_reg.y0, item_reg.y1, item_reg.y2);
        wm1  = $signed({4'b0, w_sat}) - 13'sd1;
        hm1  = $signed({4'b0, h_sat}) - 13'sd1;
        lx_s = floor_px(minx);
        ly_s = floor_px(miny);
        hx_s = ceil_px(maxx);
        hy_s = ceil_px(maxy);
        if (lx_s < 13'sd0)
        begin
            lx_s = 13'sd0;
        end
        if (ly_s < 13'sd0)
        begin
            ly_s = 13'sd0;
        end
        if (hx_s > wm1)
        begin
            hx_s = wm1;
        end
        if (hy_s > hm1)
        begin
            hy_s = hm1;
        end
        box_empty = (lx_s > hx_s) || (ly_s > hy_s);
    end

    // Per-pixel tests and addressing
    assign area_pos = !acc[ACC_W-1] && (acc != '0);
    assign covered  = !e_reg[0][EDGE_W-1] && !e_reg[1][EDGE_W-1] && !e_reg[2][EDGE_W-1];
    assign nearer   = (quo < depth_rdata);
    assign last_pix = (x_cnt_reg == hx_reg) && (y_cnt_reg == hy_reg);
    assign row_base = COUNT_W'(y_cnt_reg) * COUNT_W'(w_sat);
    assign pix_addr = ADDR_W'(row_base + COUNT_W'(x_cnt_reg));

    // Store port control
    always_comb
    begin
        ram_addr    = pix_addr;
        depth_we    = 1'b0;
        color_we    = 1'b0;
        depth_wdata = quo;
        case (state_reg)
            ST_INIT:
            begin
                ram_addr    = clr_cnt_reg;
                depth_we    = 1'b1;
                color_we    = 1'b1;
                depth_wdata = '1;
            end
            ST_CLEAR:
            begin
                ram_addr    = clr_cnt_reg;
                depth_we    = 1'b1;
                depth_wdata = '1;
            end
            ST_IDLE:
            begin
                ram_addr = item.pixel_index;
            end
            ST_MEM_CMP:
            begin
                depth_we = nearer;
                color_we = nearer;
            end
            default:
            begin
                ram_addr = pix_addr;
            end
        endcase
    end

    trd_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (STORE_SIZE)
    ) u_depth_ram (
        .clk   (clk),
        .we    (depth_we),
        .addr  (ram_addr),
        .wdata (depth_wdata),
        .rdata (depth_rdata)
    );

    trd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_SIZE)
    ) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .addr  (ram_addr),
        .wdata ((state_reg == ST_INIT) ? COLOR_W'(0) : item_reg.fill_color),
        .rdata (color_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.kind)
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_DRAW:  state_next = ST_AREA;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_AREA:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = ST_AREA_CHK;
                end
            end
            ST_AREA_CHK:
            begin
                if (!area_pos || (w_sat == '0) || (h_sat == '0) || box_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                if ((step_reg == 3'd3) && (k_reg == 2'd2))
                begin
                    state_next = ST_COVER;
                end
            end
            ST_COVER:
            begin
                if (covered)
                begin
                    state_next = ST_WSUM;
                end
                else
                begin
                    state_next = last_pix ? ST_IDLE : ST_EDGE;
                end
            end
            ST_WSUM:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MEM_RD;
                end
            end
            ST_MEM_RD:
            begin
                state_next = ST_MEM_CMP;
            end
            ST_MEM_CMP:
            begin
                state_next = last_pix ? ST_IDLE : ST_EDGE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: counters, captured values and the result word
    always_comb
    begin
        item_next         = item_reg;
        clr_cnt_next      = clr_cnt_reg;
        step_next         = 3'd0;
        k_next            = k_reg;
        e_next            = e_reg;
        area_next         = area_reg;
        x_cnt_next        = x_cnt_reg;
        y_cnt_next        = y_cnt_reg;
        lx_next           = lx_reg;
        hx_next           = hx_reg;
        hy_next           = hy_reg;
        count_next        = count_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        if (accept)
        begin
            item_next  = item;
            count_next = '0;
            k_next     = 2'd0;
        end

        case (state_reg)
            ST_INIT:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_NONE))
                begin
                    result_next       = '0;
                    result_valid_next = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    result_next       = '0;
                    result_valid_next = 1'b1;
                end
            end
            ST_READ:
            begin
                result_next            = '0;
                result_next.read_color = color_rdata;
                result_next.read_depth = depth_rdata;
                result_valid_next      = 1'b1;
            end
            ST_AREA:
            begin
                step_next = step_reg + 1'b1;
            end
            ST_AREA_CHK:
            begin
                area_next  = acc[AREA_W-1:0];
                lx_next    = lx_s[PIX_W-1:0];
                hx_next    = hx_s[PIX_W-1:0];
                hy_next    = hy_s[PIX_W-1:0];
                x_cnt_next = lx_s[PIX_W-1:0];
                y_cnt_next = ly_s[PIX_W-1:0];
                if (!area_pos || (w_sat == '0) || (h_sat == '0))
                begin
                    result_next        = '0;
                    result_next.culled = 1'b1;
                    result_valid_next  = 1'b1;
                end
                else if (box_empty)
                begin
                    result_next       = '0;
                    result_valid_next = 1'b1;
                end
            end
            ST_EDGE:
            begin
                if (step_reg == 3'd3)
                begin
                    e_next[k_reg] = acc[EDGE_W-1:0];
                    k_next        = (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WSUM:
            begin
                step_next = step_reg + 1'b1;
            end
            ST_MEM_CMP:
            begin
                if (nearer)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                step_next = 3'd0;
            end
        endcase

        // Step to the next pixel of the box, or finish the triangle
        if (((state_reg == ST_COVER) && !covered) || (state_reg == ST_MEM_CMP))
        begin
            if (last_pix)
            begin
                result_next                = '0;
                result_next.pixels_written = count_next;
                result_valid_next          = 1'b1;
            end
            else if (x_cnt_reg == hx_reg)
            begin
                x_cnt_next = lx_reg;
                y_cnt_next = y_cnt_reg + 1'b1;
            end
            else
            begin
                x_cnt_next = x_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            frame_width_reg  <= DIM_W'(MAX_WIDTH);
            frame_height_reg <= DIM_W'(MAX_HEIGHT);
            clr_cnt_reg      <= '0;
            step_reg         <= '0;
            k_reg            <= '0;
            x_cnt_reg        <= '0;
            y_cnt_reg        <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            clr_cnt_reg      <= clr_cnt_next;
            step_reg         <= step_next;
            k_reg            <= k_next;
            x_cnt_reg        <= x_cnt_next;
            y_cnt_reg        <= y_cnt_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        e_reg      <= e_next;
        area_reg   <= area_next;
        lx_reg     <= lx_next;
        hx_reg     <= hx_next;
        hy_reg     <= hy_next;
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // A result word is only shown once the block is free again
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // Every accepted word either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || result_valid))
        else $error("accepted word lost");

    // The divider only finishes while the sequencer waits for it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result outside its wait state");

    // Store writes only come from the sweeps or a passing depth test
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        depth_we |-> ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)
                      || ((state_reg == ST_MEM_CMP) && nearer)))
        else $error("unexpected depth store write");

endmodule
